[hw/rtl/mbts_pkg.sv]
// Shared types, constants and the sigmoid table of the MLP training step core.
package mbts_pkg;

  localparam int HIDDEN     = 2;
  localparam int NW         = 4 * HIDDEN + 1;
  localparam int OB         = 3 * HIDDEN;
  localparam int AW         = $clog2(NW);
  localparam int JW         = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int VALUE_W    = 16;
  localparam int FRAC       = 12;
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_LOG2   = $clog2(SIG_DEPTH);
  localparam int ACC_W      = 24;
  localparam int OPA_W      = 24;
  localparam int OPB_W      = 18;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int F_W        = PROD_W - FRAC;
  localparam int TMP_W      = 20;
  localparam logic [12:0] ONE_Q = 13'd4096;
  localparam logic [12:0] LR_RESET  = 13'd2048;
  localparam logic [12:0] MOM_RESET = 13'd3686;

  localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] CFG_MOMENTUM      = 2'd1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TRAIN = 2'd1,
    MODE_INFER = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD, OP_FI,
    OP_FH0, OP_FH1, OP_FH2, OP_FH3, OP_FH4, OP_FH5, OP_FO,
    OP_E0, OP_E1, OP_E2, OP_E3,
    OP_D0, OP_D1, OP_D2, OP_D3,
    OP_U0, OP_U1, OP_U2, OP_U3,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    G_DH, G_A_DH, G_B_DH, G_DO, G_HID_DO
  } gsel_t;

  typedef struct packed {
    op_t              op;
    logic [AW-1:0]    addr;
    logic [JW-1:0]    unit;
    gsel_t            gsel;
  } cmd_t;

  typedef logic [12:0] sig_tab_t [SIG_DEPTH];

  // Bit-serial restoring division, evaluated only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t    t;
    logic [63:0] one;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] eh;
    logic [63:0] e;
    logic [63:0] den;
    int          half;
    one  = 64'd1 << 30;
    h    = (64'd16 << 30) >> SIG_LOG2;
    term = one;
    eh   = one;
    e    = one;
    half = SIG_DEPTH / 2;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * h) >> 30, 64'(k));
      if ((k % 2) == 1) eh = eh - term;
      else eh = eh + term;
    end
    for (int m = 0; m <= half; m++) begin
      den = one + e;
      if (half + m < SIG_DEPTH)
        t[half + m] = 13'(udiv64((64'd1 << 42) + (den >> 1), den));
      if (m > 0)
        t[half - m] = 13'(udiv64((e << 12) + (den >> 1), den));
      e = (e * eh) >> 30;
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  function automatic logic [12:0] sig_lookup(input logic signed [ACC_W-1:0] x);
    logic [15:0] c;
    logic [15:0] u;
    if (x > 24'sd32767) c = 16'h7FFF;
    else if (x < -24'sd32768) c = 16'h8000;
    else c = x[15:0];
    u = {~c[15], c[14:0]};
    return SIG_TAB[u[15 -: SIG_LOG2]];
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [31:0] x);
    if (x > 32'sd32767) return 16'sh7FFF;
    else if (x < -32'sd32768) return 16'sh8000;
    else return x[VALUE_W-1:0];
  endfunction

endpackage

[hw/rtl/mbts_ctrl.sv]
// Sequencing state machine of the MLP training step core.
module mbts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic [1:0]           in_mode,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output mbts_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_FI,
    ST_FH0, ST_FH1, ST_FH2, ST_FH3, ST_FH4, ST_FH5, ST_FO,
    ST_E0, ST_E1, ST_E2, ST_E3,
    ST_D0, ST_D1, ST_D2, ST_D3,
    ST_U0, ST_U1, ST_U2, ST_U3,
    ST_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic [mbts_pkg::JW-1:0]     j_r, j_nxt;
  logic [mbts_pkg::AW-1:0]     hk_r, hk_nxt;
  logic [mbts_pkg::AW-1:0]     uk_r, uk_nxt;
  logic [1:0]                  usub_r, usub_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        accept;
  logic                        emit;
  logic                        last_j;

  assign accept     = in_tvalid && (state_r == ST_IDLE);
  assign emit       = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign last_j     = (j_r == mbts_pkg::JW'(mbts_pkg::HIDDEN - 1));
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    j_nxt     = j_r;
    hk_nxt    = hk_r;
    uk_nxt    = uk_r;
    usub_nxt  = usub_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt = in_mode;
          j_nxt    = '0;
          hk_nxt   = '0;
          case (in_mode)
            mbts_pkg::MODE_LOAD:  state_nxt = ST_LOAD;
            mbts_pkg::MODE_TRAIN: state_nxt = ST_FI;
            mbts_pkg::MODE_INFER: state_nxt = ST_FI;
            default:              state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LOAD: state_nxt = ST_DONE;
      ST_FI:   state_nxt = ST_FH0;
      ST_FH0:  state_nxt = ST_FH1;
      ST_FH1:  state_nxt = ST_FH2;
      ST_FH2:  state_nxt = ST_FH3;
      ST_FH3:  state_nxt = ST_FH4;
      ST_FH4:  state_nxt = ST_FH5;
      ST_FH5: begin
        if (last_j) begin
          j_nxt     = '0;
          state_nxt = ST_FO;
        end else begin
          j_nxt     = j_r + 1'b1;
          hk_nxt    = hk_r + mbts_pkg::AW'(3);
          state_nxt = ST_FH0;
        end
      end
      ST_FO: state_nxt = (mode_r == mbts_pkg::MODE_TRAIN) ? ST_E0 : ST_DONE;
      ST_E0: state_nxt = ST_E1;
      ST_E1: state_nxt = ST_E2;
      ST_E2: state_nxt = ST_E3;
      ST_E3: state_nxt = ST_D0;
      ST_D0: state_nxt = ST_D1;
      ST_D1: state_nxt = ST_D2;
      ST_D2: state_nxt = ST_D3;
      ST_D3: begin
        if (last_j) begin
          j_nxt     = '0;
          uk_nxt    = '0;
          usub_nxt  = '0;
          state_nxt = ST_U0;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_D0;
        end
      end
      ST_U0: state_nxt = ST_U1;
      ST_U1: state_nxt = ST_U2;
      ST_U2: state_nxt = ST_U3;
      ST_U3: begin
        if (uk_r == mbts_pkg::AW'(mbts_pkg::NW - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          uk_nxt    = uk_r + 1'b1;
          state_nxt = ST_U0;
          if (uk_r == mbts_pkg::AW'(mbts_pkg::OB - 1) || uk_r == mbts_pkg::AW'(mbts_pkg::OB)) begin
            j_nxt = '0;
          end else if (uk_r > mbts_pkg::AW'(mbts_pkg::OB)) begin
            j_nxt = j_r + 1'b1;
          end else if (usub_r == 2'd2) begin
            usub_nxt = '0;
            j_nxt    = j_r + 1'b1;
          end else begin
            usub_nxt = usub_r + 1'b1;
          end
        end
      end
      ST_DONE: if (emit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_comb begin
    cmd.op   = mbts_pkg::OP_NONE;
    cmd.addr = '0;
    cmd.unit = j_r;
    cmd.gsel = mbts_pkg::G_DH;
    case (state_r)
      ST_IDLE: if (accept) cmd.op = mbts_pkg::OP_CAPTURE;
      ST_LOAD: cmd.op = mbts_pkg::OP_LOAD;
      ST_FI: begin
        cmd.op   = mbts_pkg::OP_FI;
        cmd.addr = mbts_pkg::AW'(mbts_pkg::OB);
      end
      ST_FH0: begin
        cmd.op   = mbts_pkg::OP_FH0;
        cmd.addr = hk_r;
      end
      ST_FH1: begin
        cmd.op   = mbts_pkg::OP_FH1;
        cmd.addr = hk_r + mbts_pkg::AW'(1);
      end
      ST_FH2: begin
        cmd.op   = mbts_pkg::OP_FH2;
        cmd.addr = hk_r + mbts_pkg::AW'(2);
      end
      ST_FH3: cmd.op = mbts_pkg::OP_FH3;
      ST_FH4: begin
        cmd.op   = mbts_pkg::OP_FH4;
        cmd.addr = mbts_pkg::AW'(mbts_pkg::OB + 1) + mbts_pkg::AW'(j_r);
      end
      ST_FH5: cmd.op = mbts_pkg::OP_FH5;
      ST_FO:  cmd.op = mbts_pkg::OP_FO;
      ST_E0:  cmd.op = mbts_pkg::OP_E0;
      ST_E1:  cmd.op = mbts_pkg::OP_E1;
      ST_E2:  cmd.op = mbts_pkg::OP_E2;
      ST_E3:  cmd.op = mbts_pkg::OP_E3;
      ST_D0: begin
        cmd.op   = mbts_pkg::OP_D0;
        cmd.addr = mbts_pkg::AW'(mbts_pkg::OB + 1) + mbts_pkg::AW'(j_r);
      end
      ST_D1: cmd.op = mbts_pkg::OP_D1;
      ST_D2: cmd.op = mbts_pkg::OP_D2;
      ST_D3: cmd.op = mbts_pkg::OP_D3;
      ST_U0, ST_U1, ST_U2, ST_U3: begin
        case (state_r)
          ST_U0:   cmd.op = mbts_pkg::OP_U0;
          ST_U1:   cmd.op = mbts_pkg::OP_U1;
          ST_U2:   cmd.op = mbts_pkg::OP_U2;
          default: cmd.op = mbts_pkg::OP_U3;
        endcase
        cmd.addr = uk_r;
        if (uk_r < mbts_pkg::AW'(mbts_pkg::OB)) begin
          case (usub_r)
            2'd0:    cmd.gsel = mbts_pkg::G_DH;
            2'd1:    cmd.gsel = mbts_pkg::G_A_DH;
            default: cmd.gsel = mbts_pkg::G_B_DH;
          endcase
        end else if (uk_r == mbts_pkg::AW'(mbts_pkg::OB)) begin
          cmd.gsel = mbts_pkg::G_DO;
        end else begin
          cmd.gsel = mbts_pkg::G_HID_DO;
        end
      end
      ST_DONE: if (emit) cmd.op = mbts_pkg::OP_EMIT;
      default: cmd.op = mbts_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= '0;
      j_r         <= '0;
      hk_r        <= '0;
      uk_r        <= '0;
      usub_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      j_r         <= j_nxt;
      hk_r        <= hk_nxt;
      uk_r        <= uk_nxt;
      usub_r      <= usub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_tready) |=> (state_r == ST_DONE))
    else $error("finished item left DONE while the output register was still full");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mbts_pkg::OP_EMIT) |=> out_valid_r)
    else $error("result emitted without raising out_tvalid");

  a_uk_range: assert property (@(posedge clk) disable iff (!rst_n)
    uk_r <= mbts_pkg::AW'(mbts_pkg::NW - 1))
    else $error("update pointer ran past the weight store");

  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    j_r <= mbts_pkg::JW'(mbts_pkg::HIDDEN - 1))
    else $error("hidden unit counter out of range");

endmodule

[hw/rtl/mbts_dp.sv]
// Datapath of the MLP training step core: weight stores, shared multiplier and sigmoid table.
module mbts_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbts_pkg::cmd_t       cmd,
  input  logic signed [15:0]   in_a,
  input  logic signed [15:0]   in_b,
  input  logic [12:0]          in_target,
  input  logic [3:0]           in_weight_index,
  input  logic signed [15:0]   in_weight_value,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data,
  output logic [12:0]          net_output,
  output logic [11:0]          sample_error
);

  logic signed [15:0]                 a_r, b_r, wval_r;
  logic [12:0]                        tgt_r;
  logic [3:0]                         widx_r;
  logic [12:0]                        lr_r, mom_r;
  logic signed [15:0]                 w_r [mbts_pkg::NW];
  logic signed [15:0]                 m_r [mbts_pkg::NW];
  logic signed [mbts_pkg::ACC_W-1:0]  acc_r, osum_r;
  logic [12:0]                        hid_r [mbts_pkg::HIDDEN];
  logic signed [15:0]                 dh_r [mbts_pkg::HIDDEN];
  logic [12:0]                        o_r;
  logic [11:0]                        err_r;
  logic signed [14:0]                 diff_r;
  logic signed [15:0]                 do_r;
  logic signed [mbts_pkg::TMP_W-1:0]  tmp_r;
  logic signed [mbts_pkg::PROD_W-1:0] prod_r;
  logic [12:0]                        net_r;
  logic [11:0]                        errout_r;

  logic signed [15:0]                 w_rd, m_rd, dh_sel, chg;
  logic [12:0]                        hid_sel;
  logic signed [mbts_pkg::F_W-1:0]    prod_f;
  logic signed [mbts_pkg::OPA_W-1:0]  opa;
  logic signed [mbts_pkg::OPB_W-1:0]  opb;
  logic signed [14:0]                 diff_c;
  logic signed [mbts_pkg::ACC_W-1:0]  sig_in;
  logic [12:0]                        sig_out;
  logic [28:0]                        err_wide;

  assign w_rd    = w_r[cmd.addr];
  assign m_rd    = m_r[cmd.addr];
  assign hid_sel = hid_r[cmd.unit];
  assign dh_sel  = dh_r[cmd.unit];
  // Floor of the product over 4096: the low twelve bits are dropped.
  assign prod_f  = prod_r[mbts_pkg::PROD_W-1:mbts_pkg::FRAC];
  assign diff_c  = $signed({2'b00, tgt_r}) - $signed({2'b00, o_r});
  assign err_wide = prod_r[41:13];
  assign chg     = mbts_pkg::sat_val(32'(tmp_r) + 32'(prod_f));
  assign sig_in  = (cmd.op == mbts_pkg::OP_FH3) ? acc_r + prod_f[mbts_pkg::ACC_W-1:0] : osum_r;
  assign sig_out = mbts_pkg::sig_lookup(sig_in);

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      mbts_pkg::OP_FH1: begin
        opa = mbts_pkg::OPA_W'(a_r);
        opb = mbts_pkg::OPB_W'(w_rd);
      end
      mbts_pkg::OP_FH2: begin
        opa = mbts_pkg::OPA_W'(b_r);
        opb = mbts_pkg::OPB_W'(w_rd);
      end
      mbts_pkg::OP_FH4: begin
        opa = mbts_pkg::OPA_W'(w_rd);
        opb = $signed({5'b0, hid_sel});
      end
      mbts_pkg::OP_E0: begin
        opa = mbts_pkg::OPA_W'(diff_c);
        opb = mbts_pkg::OPB_W'(diff_c);
      end
      mbts_pkg::OP_E1: begin
        opa = mbts_pkg::OPA_W'(diff_r);
        opb = $signed({5'b0, o_r});
      end
      mbts_pkg::OP_E2: begin
        opa = prod_f[mbts_pkg::OPA_W-1:0];
        opb = $signed({5'b0, mbts_pkg::ONE_Q - o_r});
      end
      mbts_pkg::OP_D0: begin
        opa = mbts_pkg::OPA_W'(w_rd);
        opb = mbts_pkg::OPB_W'(do_r);
      end
      mbts_pkg::OP_D1: begin
        opa = prod_f[mbts_pkg::OPA_W-1:0];
        opb = $signed({5'b0, hid_sel});
      end
      mbts_pkg::OP_D2: begin
        opa = prod_f[mbts_pkg::OPA_W-1:0];
        opb = $signed({5'b0, mbts_pkg::ONE_Q - hid_sel});
      end
      mbts_pkg::OP_U0: begin
        // A bare delta is passed through as a product with one.
        case (cmd.gsel)
          mbts_pkg::G_A_DH:   opa = mbts_pkg::OPA_W'(a_r);
          mbts_pkg::G_B_DH:   opa = mbts_pkg::OPA_W'(b_r);
          mbts_pkg::G_HID_DO: opa = $signed({11'b0, hid_sel});
          default:            opa = $signed({11'b0, mbts_pkg::ONE_Q});
        endcase
        if (cmd.gsel == mbts_pkg::G_DO || cmd.gsel == mbts_pkg::G_HID_DO) opb = mbts_pkg::OPB_W'(do_r);
        else opb = mbts_pkg::OPB_W'(dh_sel);
      end
      mbts_pkg::OP_U1: begin
        opa = prod_f[mbts_pkg::OPA_W-1:0];
        opb = $signed({5'b0, lr_r});
      end
      mbts_pkg::OP_U2: begin
        opa = mbts_pkg::OPA_W'(m_rd);
        opb = $signed({5'b0, mom_r});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= mbts_pkg::LR_RESET;
      mom_r <= mbts_pkg::MOM_RESET;
      for (int i = 0; i < mbts_pkg::NW; i++) begin
        w_r[i] <= '0;
        m_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mbts_pkg::CFG_LEARNING_RATE: lr_r  <= cfg_data;
          mbts_pkg::CFG_MOMENTUM:      mom_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        mbts_pkg::OP_LOAD: begin
          if (widx_r < 4'(mbts_pkg::NW)) begin
            w_r[widx_r[mbts_pkg::AW-1:0]] <= wval_r;
            m_r[widx_r[mbts_pkg::AW-1:0]] <= '0;
          end
        end
        mbts_pkg::OP_U3: begin
          m_r[cmd.addr] <= chg;
          w_r[cmd.addr] <= mbts_pkg::sat_val(32'(w_rd) + 32'(chg));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mbts_pkg::OP_CAPTURE: begin
        a_r    <= in_a;
        b_r    <= in_b;
        tgt_r  <= in_target;
        widx_r <= in_weight_index;
        wval_r <= in_weight_value;
        o_r    <= '0;
        err_r  <= '0;
      end
      mbts_pkg::OP_FI:  osum_r <= mbts_pkg::ACC_W'(w_rd);
      mbts_pkg::OP_FH0: acc_r  <= mbts_pkg::ACC_W'(w_rd);
      mbts_pkg::OP_FH2: acc_r  <= acc_r + prod_f[mbts_pkg::ACC_W-1:0];
      mbts_pkg::OP_FH3: hid_r[cmd.unit] <= sig_out;
      mbts_pkg::OP_FH5: osum_r <= osum_r + prod_f[mbts_pkg::ACC_W-1:0];
      mbts_pkg::OP_FO:  o_r    <= sig_out;
      mbts_pkg::OP_E0:  diff_r <= diff_c;
      mbts_pkg::OP_E1:  err_r  <= (err_wide > 29'd4095) ? 12'hFFF : err_wide[11:0];
      mbts_pkg::OP_E3:  do_r   <= mbts_pkg::sat_val(32'(prod_f));
      mbts_pkg::OP_D3:  dh_r[cmd.unit] <= mbts_pkg::sat_val(32'(prod_f));
      mbts_pkg::OP_U2:  tmp_r  <= prod_f[mbts_pkg::TMP_W-1:0];
      mbts_pkg::OP_EMIT: begin
        net_r    <= o_r;
        errout_r <= err_r;
      end
      default: ;
    endcase
  end

  assign net_output   = net_r;
  assign sample_error = errout_r;

endmodule

[hw/rtl/mlp_backprop_training_step_core.sv]
// Top level of the MLP training step core: ports, packing and the two sub-blocks.
// Train walks 6*H + 4*H + 4*(4*H+1) + 7 sequencer states, with two hidden units (H),
// and those states share one 24x18 multiplier, which not every state uses. One item is
// in flight; the next is taken once its result has reached the output register.
// Synchronous reset clears weights and momentum terms and sets the rate to 0.5 and
// momentum to 0.9.
module mlp_backprop_training_step_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_a[15:0], in_b[31:16], target[44:32], weight_index[48:45],
  // weight_value[64:49], zero padding above.
  input  logic [71:0] in_tdata,
  // mode[1:0], zero padding above.
  input  logic [7:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // net_output[12:0], sample_error[24:13], zero padding above.
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  mbts_pkg::cmd_t cmd;
  logic [12:0]    net_output;
  logic [11:0]    sample_error;

  // Configuration writes are always taken; rate and momentum writes land in the datapath registers, others are dropped.
  assign cfg_ready = 1'b1;

  mbts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser[1:0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mbts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_a            (in_tdata[15:0]),
    .in_b            (in_tdata[31:16]),
    .in_target       (in_tdata[44:32]),
    .in_weight_index (in_tdata[48:45]),
    .in_weight_value (in_tdata[64:49]),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .net_output      (net_output),
    .sample_error    (sample_error)
  );

  assign out_tdata = {7'b0, sample_error, net_output};

endmodule
